// ----- design/dq_pkg.sv -----
// Shared constants and helpers for the character deque with vowel scan.
// Holds command and status codes, field widths and the vowel test.
// Used by every design file and by the port checker.
package dq_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int CMD_W  = 3;
    localparam int CHAR_W = 8;
    localparam int STAT_W = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LIST_ALL    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_LIST_VOWELS = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOVOWEL = 2'd3;

    localparam logic [CHAR_W-1:0] CHAR_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_E = 8'h65;
    localparam logic [CHAR_W-1:0] CHAR_I = 8'h69;
    localparam logic [CHAR_W-1:0] CHAR_O = 8'h6f;
    localparam logic [CHAR_W-1:0] CHAR_U = 8'h75;

    function automatic logic is_vowel(input logic [CHAR_W-1:0] c);
        return (c == CHAR_A) || (c == CHAR_E) || (c == CHAR_I) ||
               (c == CHAR_O) || (c == CHAR_U);
    endfunction

endpackage

// ----- design/dq_ring_ram.sv -----
// Character store of the deque: one write port and one registered read port.
// Depends on dq_pkg for the character width.
module dq_ring_ram #(
    parameter int DEPTH = dq_pkg::CAPACITY_DEF
) (
    input  logic                            aclk,
    input  logic                            we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [dq_pkg::CHAR_W-1:0]       wdata,
    input  logic                            re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [dq_pkg::CHAR_W-1:0]       rdata
);

    logic [dq_pkg::CHAR_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- design/dq_idx_unit.sv -----
// Shared ring index adder: (base + offset) modulo the deque capacity.
// The offset never exceeds the capacity, so one compare and subtract wraps it.
module dq_idx_unit #(
    parameter int CAPACITY = dq_pkg::CAPACITY_DEF
) (
    input  logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] base,
    input  logic [$clog2(CAPACITY + 1)-1:0]                  offset,
    output logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] sum
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [SUM_W-1:0] CAP_S = SUM_W'(CAPACITY);

    logic [SUM_W-1:0] raw;
    logic [SUM_W-1:0] wrapped;

    always_comb begin
        raw = SUM_W'(base) + SUM_W'(offset);
        if (raw >= CAP_S) begin
            wrapped = raw - CAP_S;
        end else begin
            wrapped = raw;
        end
    end

    assign sum = wrapped[IDX_W-1:0];

endmodule

// ----- design/char_deque_with_vowel_scan.sv -----
// Bounded character deque on a ring buffer, with full and vowel listings.
// Push and pop: the command is registered in S_IDLE and its status word is registered in S_EXEC.
// Listing: S_EXEC, then S_READ and S_CHECK for each entry, then S_FINISH gives the last word.
// One command at a time; s_tready is high only while the sequencer is idle, and stalls add cycles.
// Synchronous active-low reset empties the deque; stored characters are kept.
module char_deque_with_vowel_scan #(
    parameter int CAPACITY = dq_pkg::CAPACITY_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [dq_pkg::CHAR_W-1:0]   s_tdata,   // char_in
    input  logic [dq_pkg::CMD_W-1:0]    s_tuser,   // cmd
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [dq_pkg::CHAR_W-1:0]   m_tdata,   // char_out
    output logic [dq_pkg::STAT_W-1:0]   m_tuser,   // status
    output logic                        m_tlast
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_C  = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] CAP_M1 = CNT_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] ONE_C  = CNT_W'(1);

    typedef enum logic [2:0] {S_IDLE, S_EXEC, S_READ, S_CHECK, S_FINISH} state_t;

    state_t                     state_reg, state_next;
    logic [dq_pkg::CMD_W-1:0]   cmd_reg, cmd_next;
    logic [dq_pkg::CHAR_W-1:0]  char_reg, char_next;
    logic [IDX_W-1:0]           front_reg, front_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [CNT_W-1:0]           walk_reg, walk_next;
    logic                       pend_valid_reg, pend_valid_next;
    logic [dq_pkg::CHAR_W-1:0]  pend_char_reg, pend_char_next;
    logic                       out_valid_reg, out_valid_next;
    logic [dq_pkg::CHAR_W-1:0]  out_char_reg, out_char_next;
    logic [dq_pkg::STAT_W-1:0]  out_stat_reg, out_stat_next;
    logic                       out_last_reg, out_last_next;

    logic [CNT_W-1:0]           idx_offset;
    logic [IDX_W-1:0]           idx_sum;
    logic                       ram_we;
    logic                       ram_re;
    logic [dq_pkg::CHAR_W-1:0]  ram_rdata;
    logic                       slot_free;
    logic                       hit;
    logic                       is_full;
    logic                       is_empty;

    dq_idx_unit #(.CAPACITY(CAPACITY)) u_idx (
        .base   (front_reg),
        .offset (idx_offset),
        .sum    (idx_sum)
    );

    dq_ring_ram #(.DEPTH(CAPACITY)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (idx_sum),
        .wdata (char_reg),
        .re    (ram_re),
        .raddr (idx_sum),
        .rdata (ram_rdata)
    );

    assign slot_free = !out_valid_reg || m_tready;
    assign is_full   = (count_reg == CAP_C);
    assign is_empty  = (count_reg == '0);
    assign hit       = (cmd_reg == dq_pkg::CMD_LIST_ALL) || dq_pkg::is_vowel(ram_rdata);

    always_comb begin
        if (state_reg == S_READ) begin
            idx_offset = walk_reg;
        end else if (cmd_reg == dq_pkg::CMD_PUSH_FRONT) begin
            idx_offset = CAP_M1;
        end else if (cmd_reg == dq_pkg::CMD_PUSH_BACK) begin
            idx_offset = count_reg;
        end else begin
            idx_offset = ONE_C;
        end
    end

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        char_next       = char_reg;
        front_next      = front_reg;
        count_next      = count_reg;
        walk_next       = walk_reg;
        pend_valid_next = pend_valid_reg;
        pend_char_next  = pend_char_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_char_next   = out_char_reg;
        out_stat_next   = out_stat_reg;
        out_last_next   = out_last_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next   = s_tuser;
                    char_next  = s_tdata;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                case (cmd_reg) inside
                    dq_pkg::CMD_PUSH_FRONT, dq_pkg::CMD_PUSH_BACK: begin
                        if (slot_free) begin
                            out_valid_next = 1'b1;
                            out_char_next  = '0;
                            out_last_next  = 1'b1;
                            out_stat_next  = is_full ? dq_pkg::ST_FULL : dq_pkg::ST_OK;
                            if (!is_full) begin
                                ram_we     = 1'b1;
                                count_next = count_reg + ONE_C;
                                if (cmd_reg == dq_pkg::CMD_PUSH_FRONT) begin
                                    front_next = idx_sum;
                                end
                            end
                            state_next = S_IDLE;
                        end
                    end
                    dq_pkg::CMD_POP_FRONT, dq_pkg::CMD_POP_BACK: begin
                        if (slot_free) begin
                            out_valid_next = 1'b1;
                            out_char_next  = '0;
                            out_last_next  = 1'b1;
                            out_stat_next  = is_empty ? dq_pkg::ST_EMPTY : dq_pkg::ST_OK;
                            if (!is_empty) begin
                                count_next = count_reg - ONE_C;
                                if (cmd_reg == dq_pkg::CMD_POP_FRONT) begin
                                    front_next = idx_sum;
                                end
                            end
                            state_next = S_IDLE;
                        end
                    end
                    dq_pkg::CMD_LIST_ALL, dq_pkg::CMD_LIST_VOWELS: begin
                        if (is_empty) begin
                            if (slot_free) begin
                                out_valid_next = 1'b1;
                                out_char_next  = '0;
                                out_stat_next  = dq_pkg::ST_EMPTY;
                                out_last_next  = 1'b1;
                                state_next     = S_IDLE;
                            end
                        end else begin
                            walk_next       = '0;
                            pend_valid_next = 1'b0;
                            state_next      = S_READ;
                        end
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_READ: begin
                ram_re     = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK: begin
                if (!(hit && pend_valid_reg && !slot_free)) begin
                    if (hit) begin
                        if (pend_valid_reg) begin
                            out_valid_next = 1'b1;
                            out_char_next  = pend_char_reg;
                            out_stat_next  = dq_pkg::ST_OK;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_char_next  = ram_rdata;
                    end
                    walk_next  = walk_reg + ONE_C;
                    state_next = (walk_reg + ONE_C == count_reg) ? S_FINISH : S_READ;
                end
            end
            S_FINISH: begin
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    if (pend_valid_reg) begin
                        out_char_next = pend_char_reg;
                        out_stat_next = dq_pkg::ST_OK;
                    end else begin
                        out_char_next = '0;
                        out_stat_next = dq_pkg::ST_NOVOWEL;
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            front_reg      <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            front_reg      <= front_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
        cmd_reg       <= cmd_next;
        char_reg      <= char_next;
        walk_reg      <= walk_next;
        pend_char_reg <= pend_char_next;
        out_char_reg  <= out_char_next;
        out_stat_reg  <= out_stat_next;
        out_last_reg  <= out_last_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tuser  = out_stat_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ----- design/dq_checker.sv -----
// Port-level checker for the character deque, attached to the top level by bind.
// Depends on dq_pkg for status codes and field widths.
module dq_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic [dq_pkg::CHAR_W-1:0]   s_tdata,
    input logic [dq_pkg::CMD_W-1:0]    s_tuser,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [dq_pkg::CHAR_W-1:0]   m_tdata,
    input logic [dq_pkg::STAT_W-1:0]   m_tuser,
    input logic                        m_tlast
);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("Result word valid right after reset.");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("Input accepted while a command was still in work.");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("Stalled result word changed.");

    a_status_word_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != dq_pkg::ST_OK) |-> m_tlast && (m_tdata == '0))
        else $error("Status word carries data or is not last.");

    a_ready_only_when_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("Ready for a new command before a listing finished.");

endmodule

bind char_deque_with_vowel_scan dq_checker u_dq_checker (.*);
